// ===== sv/pbo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_pkg
// Types and codes shared by the blink output controller files.
// ----------------------------------------------------------------------------
package pbo_pkg;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_PERM  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [1:0] CFG_PORTS_IN_USE = 2'd0;
    localparam logic [1:0] CFG_INIT_LEVELS  = 2'd1;

    localparam int         CFG_DW           = 8;
    localparam logic [1:0] PORTS_IN_USE_RST = 2'd3;
    localparam logic [15:0] FOREVER         = 16'hffff;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  port;
        logic [1:0]  priority_req;
        logic [15:0] repeat_count;
        logic [7:0]  high_ticks;
        logic [7:0]  low_ticks;
    } t_cmd;

    typedef struct packed {
        logic [1:0] out_port;
        logic       out_level;
        logic       out_active;
        logic       cycles_done;
        logic [1:0] done_priority;
        logic       last;
    } t_res;

    // one slot record as held in the slot memory
    typedef struct packed {
        logic [15:0] repeats_left;
        logic [7:0]  high_period;
        logic [7:0]  low_period;
        logic [7:0]  high_left;
        logic [7:0]  low_left;
    } t_slot;

    // outcome of one tick on a slot
    typedef struct packed {
        logic level_set;
        logic level_val;
        logic done;
        logic still_busy;
    } t_upd;

endpackage

// ===== sv/pbo_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_slot_ram
// Slot record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbo_slot_ram
    import pbo_pkg::*;
#(
    parameter int DEPTH = 12,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pbo_slot_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbo_slot_update
// One tick of countdown on a slot record: high phase, low phase, period end.
// ----------------------------------------------------------------------------
module pbo_slot_update
    import pbo_pkg::*;
(
    input  t_slot i_slot,
    output t_slot o_slot,
    output t_upd  o_upd
);

    logic [7:0]  lo_next;
    logic [15:0] rep_next;

    always_comb begin
        o_slot   = i_slot;
        o_upd    = '0;
        lo_next  = '0;
        rep_next = i_slot.repeats_left;
        if (i_slot.high_left != 8'd0) begin
            o_slot.high_left = i_slot.high_left - 8'd1;
            o_upd.level_set  = 1'b1;
            o_upd.level_val  = 1'b1;
        end else begin
            if (i_slot.low_left != 8'd0) begin
                lo_next         = i_slot.low_left - 8'd1;
                o_upd.level_set = 1'b1;
                o_upd.level_val = 1'b0;
            end
            o_slot.low_left = lo_next;
            // period over: count it and reload
            if (lo_next == 8'd0) begin
                if (i_slot.repeats_left != FOREVER) begin
                    rep_next = i_slot.repeats_left - 16'd1;
                end
                o_slot.repeats_left = rep_next;
                o_upd.done          = (rep_next == 16'd0);
                o_slot.high_left    = i_slot.high_period;
                o_slot.low_left     = i_slot.low_period;
            end
        end
        o_upd.still_busy = (o_slot.repeats_left != 16'd0);
    end

endmodule

// ===== sv/priority_blink_output_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_blink_output_controller
// Blink pattern generator with prioritised slots per output port.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Start, stop,
// start-permanent and query give one result word the cycle after, when the
// port is served and, for start and stop, the priority is in range. A tick
// walks the served ports in order: a port with no slot to serve is reported
// from the scan state; otherwise the scan state reads the slot memory, then
// the update state updates the record and writes it back.
// Result words appear one per port, each for exactly one cycle with
// o_res_strobe; the receiver cannot stall them, so it must take every one.
// Slot memory needs no clearing after reset: per-slot busy flags say which
// records are live, and a record is always written whole when started.
// Configuration writes are taken only while idle and no word is offered.
// ----------------------------------------------------------------------------
module priority_blink_output_controller
    import pbo_pkg::*;
#(
    parameter int NUM_PORTS      = 3,
    parameter int NUM_PRIORITIES = 4,
    parameter int RED_PORT       = 0,
    parameter int GREEN_PORT     = 1,
    parameter int MIX_PORT       = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    input  t_cmd              i_cmd,
    output logic              busy,
    // result channel
    output logic              o_res_strobe,
    output t_res              o_res,
    // configuration channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int PW     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int SW     = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
    localparam int DEPTH  = NUM_PORTS * NUM_PRIORITIES;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NP_CAP = (NUM_PORTS > 3) ? 3 : NUM_PORTS;
    // red/green only gate the mixed port when they exist
    localparam bit RED_OK    = (RED_PORT < NUM_PORTS);
    localparam bit GREEN_OK  = (GREEN_PORT < NUM_PORTS);
    localparam int RED_IDX   = RED_OK ? RED_PORT : 0;
    localparam int GREEN_IDX = GREEN_OK ? GREEN_PORT : 0;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} t_state;

    t_state r_state, n_state;
    logic [1:0] r_ports, n_ports;
    logic [2:0] r_init, n_init;
    logic [NUM_PORTS-1:0] r_level, n_level;
    logic [NUM_PORTS-1:0] r_active, n_active;
    logic [NUM_PORTS-1:0][NUM_PRIORITIES-1:0] r_busy, n_busy;
    logic [1:0]    r_port, n_port;    // port being walked on a tick
    logic [SW-1:0] r_slot, n_slot;    // slot read for the port in hand
    logic r_strobe, n_strobe;
    t_res r_res, n_res;

    // slot memory interface
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_slot         ram_wdata, ram_rdata;
    t_slot         upd_slot;
    t_upd          upd;

    logic [1:0]    served;
    logic [PW-1:0] cmd_idx, tick_idx;
    logic          last_port, pr_ok, times_nz, cmd_emit;
    logic [SW-1:0] ld_slot;
    logic [15:0]   ld_rep;
    logic [NUM_PRIORITIES-1:0] red_busy, green_busy;
    logic          is_mix, sel_found, sel_stop;
    logic [SW-1:0] sel_slot;

    function automatic logic [AW-1:0] slot_addr(input logic [PW-1:0] p,
                                                 input logic [SW-1:0] s);
        return AW'(int'(p) * NUM_PRIORITIES + int'(s));
    endfunction

    pbo_slot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pbo_slot_update u_upd (
        .i_slot (ram_rdata),
        .o_slot (upd_slot),
        .o_upd  (upd)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE) && !start;
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // ports served on a tick, and command fields
    assign served    = (int'(r_ports) < NP_CAP) ? r_ports : 2'(NP_CAP);
    assign cmd_idx   = PW'(i_cmd.port);
    assign tick_idx  = PW'(r_port);
    assign last_port = (r_port == served - 2'd1);
    assign pr_ok     = (int'(i_cmd.priority_req) < NUM_PRIORITIES);
    assign times_nz  = (i_cmd.high_ticks != 8'd0) || (i_cmd.low_ticks != 8'd0);
    assign is_mix    = (int'(r_port) == MIX_PORT);
    assign red_busy   = RED_OK ? r_busy[RED_IDX] : '0;
    assign green_busy = GREEN_OK ? r_busy[GREEN_IDX] : '0;

    // first live slot of the walked port; the mixed port gives way at the
    // first slot level where red or green is live
    always_comb begin
        sel_found = 1'b0;
        sel_stop  = 1'b0;
        sel_slot  = '0;
        for (int j = 0; j < NUM_PRIORITIES; j++) begin
            if (!sel_found && !sel_stop) begin
                if (is_mix && (red_busy[j] || green_busy[j])) begin
                    sel_stop = 1'b1;
                end else if (r_busy[tick_idx][j]) begin
                    sel_found = 1'b1;
                    sel_slot  = SW'(j);
                end
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ports   = r_ports;
        n_init    = r_init;
        n_level   = r_level;
        n_active  = r_active;
        n_busy    = r_busy;
        n_port    = r_port;
        n_slot    = r_slot;
        n_strobe  = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = '0;
        ram_raddr = '0;
        ram_wdata = upd_slot;
        cmd_emit  = 1'b0;
        ld_slot   = (i_cmd.op == OP_PERM) ? SW'(NUM_PRIORITIES - 1) : SW'(i_cmd.priority_req);
        ld_rep    = (i_cmd.op == OP_PERM) ? FOREVER : i_cmd.repeat_count;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd.op == OP_TICK) begin
                        if (served != 2'd0) begin
                            n_port  = 2'd0;
                            n_state = S_SCAN;
                        end
                    end else if (i_cmd.port < served) begin
                        case (i_cmd.op)
                            OP_START, OP_PERM: begin
                                if (i_cmd.op == OP_PERM || pr_ok) begin
                                    cmd_emit = 1'b1;
                                    if (times_nz && ld_rep != 16'd0) begin
                                        ram_we    = 1'b1;
                                        ram_waddr = slot_addr(cmd_idx, ld_slot);
                                        ram_wdata = '{repeats_left: ld_rep,
                                                      high_period:  i_cmd.high_ticks,
                                                      low_period:   i_cmd.low_ticks,
                                                      high_left:    i_cmd.high_ticks,
                                                      low_left:     i_cmd.low_ticks};
                                        n_busy[cmd_idx][ld_slot] = 1'b1;
                                    end
                                end
                            end
                            OP_STOP: begin
                                if (pr_ok) begin
                                    cmd_emit = 1'b1;
                                    n_busy[cmd_idx][ld_slot] = 1'b0;
                                    n_level[cmd_idx]         = 1'b0;
                                end
                            end
                            OP_QUERY: begin
                                cmd_emit = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                if (cmd_emit) begin
                    n_strobe = 1'b1;
                    n_res    = '{out_port: i_cmd.port, out_level: n_level[cmd_idx],
                                 out_active: r_active[cmd_idx], cycles_done: 1'b0,
                                 done_priority: 2'd0, last: 1'b1};
                end
                // register writes, only taken while idle
                if (i_cfg_valid && o_cfg_ready) begin
                    case (i_cfg_index)
                        CFG_PORTS_IN_USE: n_ports = i_cfg_data[1:0];
                        CFG_INIT_LEVELS: begin
                            n_init = i_cfg_data[2:0];
                            for (int i = 0; i < NUM_PORTS; i++) begin
                                n_level[i] = 1'(i_cfg_data[2:0] >> i);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (sel_found) begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_addr(tick_idx, sel_slot);
                    n_slot    = sel_slot;
                    n_state   = S_UPD;
                end else begin
                    // nothing live: report the port as is
                    n_active[tick_idx] = 1'b0;
                    n_strobe = 1'b1;
                    n_res    = '{out_port: r_port, out_level: r_level[tick_idx],
                                 out_active: 1'b0, cycles_done: 1'b0,
                                 done_priority: 2'd0, last: last_port};
                    n_port   = r_port + 2'd1;
                    n_state  = last_port ? S_IDLE : S_SCAN;
                end
            end
            S_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(tick_idx, r_slot);
                n_busy[tick_idx][r_slot] = upd.still_busy;
                n_active[tick_idx]       = 1'b1;
                if (upd.level_set) begin
                    n_level[tick_idx] = upd.level_val;
                end
                n_strobe = 1'b1;
                n_res    = '{out_port: r_port, out_level: n_level[tick_idx],
                             out_active: 1'b1, cycles_done: upd.done,
                             done_priority: upd.done ? 2'(r_slot) : 2'd0,
                             last: last_port};
                n_port   = r_port + 2'd1;
                n_state  = last_port ? S_IDLE : S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ports  <= PORTS_IN_USE_RST;
            r_init   <= '0;
            r_level  <= '0;
            r_active <= '0;
            r_busy   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ports  <= n_ports;
            r_init   <= n_init;
            r_level  <= n_level;
            r_active <= n_active;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
            r_port   <= n_port;
            r_slot   <= n_slot;
            r_res    <= n_res;
        end
    end

    // the last word of an item leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.last |-> !busy)
        else $error("last result word while still busy");

    // only ticks give non-final words, and the walk goes on after them
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.last |-> busy)
        else $error("non-final result word with controller idle");

    // update always follows a slot read
    a_upd_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPD |-> $past(ram_re))
        else $error("slot update without preceding read");

    // the controller never reads and writes the slot memory in one cycle
    a_ram_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("slot memory read and write collide");

    // a finished slot was controlling the port
    a_done_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && o_res.cycles_done |-> o_res.out_active)
        else $error("done flag on inactive port");

endmodule
